// ===== hdl/a32_pkg.sv =====
// ----------------------------------------------------------------------------
// a32_pkg: shared types and constants for the Adler-32 lane checksum
// Widths, modulus, register indexes and the records passed between stages.
// ----------------------------------------------------------------------------
package a32_pkg;

  localparam int MAX_LANES = 8;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 4;
  localparam int SUM_W     = 16;
  localparam int S1_W      = 11;   // 8 x 255 = 2040
  localparam int WB_W      = 11;   // 255 x 8 = 2040, one lane's weighted byte
  localparam int PROD_W    = BYTE_W + CNT_W;
  localparam int S2_W      = 14;   // 36 x 255 = 9180
  localparam int BX_W      = 20;   // b + n*a + s2 stays below 2^20
  localparam int HI_W      = BX_W - SUM_W;
  localparam int FOLD_W    = 8;
  localparam int DATA_W    = 64;
  localparam int S_TDATA_W = 72;   // 64 data + 4 count, padded to bytes
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [SUM_W:0]    ADLER_MOD = 17'd65521;
  // 2^16 mod 65521
  localparam logic [FOLD_W-1:0] ADLER_FOLD = 8'd15;

  localparam logic [SUM_W-1:0] SEED_A_RST = 16'd1;
  localparam logic [SUM_W-1:0] SEED_B_RST = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED_A = 1'b0,
    CFG_SEED_B = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_v;   // byte if valid, else zero
    logic [WB_W-1:0]   wbyte;    // byte times its weight into sum B
  } lane_t;

  typedef struct packed {
    logic [S2_W-1:0] s2;
    logic [S1_W-1:0] s1;
  } sums_t;

  typedef struct packed {
    logic             first;
    logic [CNT_W-1:0] n;
  } ctl_t;

endpackage

// ===== hdl/a32_lane.sv =====
// ----------------------------------------------------------------------------
// a32_lane: one byte lane
// Masks its byte against the count and forms its weight into sum B.
// ----------------------------------------------------------------------------
module a32_lane import a32_pkg::*; #(
  parameter int LANE_IDX = 0
) (
  input  logic              clk,
  input  logic              load,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic [CNT_W-1:0]  count,
  output lane_t             lane_out
);

  logic [CNT_W-1:0]  weight;
  logic [PROD_W-1:0] prod;
  logic              valid_byte;
  lane_t             lane_next;

  // byte k is added (n - k) times into sum B
  assign valid_byte = count > CNT_W'(LANE_IDX);
  assign weight     = valid_byte ? (count - CNT_W'(LANE_IDX)) : '0;
  assign prod       = {{CNT_W{1'b0}}, byte_in} * {{BYTE_W{1'b0}}, weight};

  always_comb begin
    lane_next.byte_v = valid_byte ? byte_in : '0;
    lane_next.wbyte  = prod[WB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lane_out <= lane_next;
    end
  end

endmodule

// ===== hdl/a32_merge.sv =====
// ----------------------------------------------------------------------------
// a32_merge: lane merge
// Adds the lane contributions into the byte sum and the weighted sum.
// ----------------------------------------------------------------------------
module a32_merge import a32_pkg::*; #(
  parameter int LANES = MAX_LANES
) (
  input  logic  clk,
  input  logic  load,
  input  lane_t lanes [LANES],
  output sums_t sums
);

  sums_t sums_next;

  always_comb begin
    sums_next = '0;
    for (int k = 0; k < LANES; k++) begin
      sums_next.s1 = sums_next.s1 + S1_W'(lanes[k].byte_v);
      sums_next.s2 = sums_next.s2 + S2_W'(lanes[k].wbyte);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sums <= sums_next;
    end
  end

endmodule

// ===== hdl/a32_accum.sv =====
// ----------------------------------------------------------------------------
// a32_accum: running sums
// Adds an item's lane sums to A and B and reduces both modulo 65521.
// ----------------------------------------------------------------------------
module a32_accum import a32_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ctl_t             ctl,
  input  sums_t            sums,
  input  logic [SUM_W-1:0] seed_a,
  input  logic [SUM_W-1:0] seed_b,
  output logic [SUM_W-1:0] acc_a,
  output logic [SUM_W-1:0] acc_b
);

  logic [SUM_W-1:0]  a0;
  logic [SUM_W-1:0]  b0;
  logic [SUM_W:0]    a_raw;
  logic [BX_W-1:0]   na;
  logic [BX_W-1:0]   b_raw;
  logic [FOLD_W-1:0] hi15;
  logic [SUM_W:0]    b_fold;
  logic [SUM_W-1:0]  acc_a_next;
  logic [SUM_W-1:0]  acc_b_next;

  assign a0 = ctl.first ? seed_a : acc_a;
  assign b0 = ctl.first ? seed_b : acc_b;

  // A: at most 65535 + 2040, one subtract reduces it
  assign a_raw      = {1'b0, a0} + (SUM_W+1)'(sums.s1);
  assign acc_a_next = (a_raw >= ADLER_MOD) ? SUM_W'(a_raw - ADLER_MOD) : a_raw[SUM_W-1:0];

  // B: b0 + n*a0 + weighted sum, below 10 x 65521
  assign na    = {{SUM_W{1'b0}}, ctl.n} * {{CNT_W{1'b0}}, a0};
  assign b_raw = BX_W'(b0) + na + BX_W'(sums.s2);

  // fold the top bits back in (2^16 = 15 mod 65521), then one subtract
  assign hi15       = FOLD_W'(b_raw[BX_W-1:SUM_W]) * ADLER_FOLD;
  assign b_fold     = {1'b0, b_raw[SUM_W-1:0]} + (SUM_W+1)'(hi15);
  assign acc_b_next = (b_fold >= ADLER_MOD) ? SUM_W'(b_fold - ADLER_MOD)
                                            : b_fold[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_a <= SEED_A_RST;
      acc_b <= SEED_B_RST;
    end else if (load) begin
      acc_a <= acc_a_next;
      acc_b <= acc_b_next;
    end
  end

endmodule

// ===== hdl/adler32_checksum_lanes.sv =====
// ----------------------------------------------------------------------------
// adler32_checksum_lanes: Adler-32 running checksum, up to eight bytes a word
// Lane stage, merge stage and accumulate stage behind a stream handshake.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream s_*: each word carries up to LANES bytes, byte zero first,
//   with a count of valid bytes (counts above LANES saturate). tuser is the
//   first flag: it reloads sum A and sum B from the seed registers before the
//   word's bytes are added. Master stream m_*: one word out per word in,
//   holding the reduced sums and the packed checksum, in input order.
//   Seeds must be written over the cfg port while no word is in flight; the block does not enforce it.
//   Output: an accepted word passes the lane register, the merge register
//   and the accumulator in that order before m_tvalid. Throughput: one word
//   per clock while m_tready is high; the limit is the accumulate loop (n*a
//   multiply, add, fold and final subtract), a combinational feedback path.
//   Reset: all stages empty, sum A = 1, sum B = 0, seeds back to 1 and 0.
//   Stall: a low m_tready freezes the output word; earlier stages keep
//   filling until each is occupied, so s_tready drops only with the pipe full.
// ----------------------------------------------------------------------------
module adler32_checksum_lanes import a32_pkg::*; #(
  parameter int LANES = MAX_LANES
) (
  input  logic                 clk,
  input  logic                 rst,
  // slave stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // data_bytes[63:0], byte_count[67:64], zero pad
  input  logic [S_TUSER_W-1:0] s_tuser,   // first[0]
  // master stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // sum_a[15:0], sum_b[31:16], checksum[63:32]
  // config
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SUM_W-1:0]     cfg_data
);

  logic [SUM_W-1:0] seed_a;
  logic [SUM_W-1:0] seed_b;
  cfg_idx_t         cfg_sel;

  logic             valid_a;
  logic             valid_b;
  logic             rdy_a;
  logic             rdy_b;
  logic             rdy_c;
  logic             load_a;
  logic             load_b;
  logic             load_c;

  logic [CNT_W-1:0] s_count;
  logic [CNT_W-1:0] n_sat;
  ctl_t             ctl_a;
  ctl_t             ctl_b;
  lane_t            lanes [LANES];
  sums_t            sums;
  logic [SUM_W-1:0] acc_a;
  logic [SUM_W-1:0] acc_b;

  // ---- config registers ----
  assign cfg_sel = cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_a <= SEED_A_RST;
      seed_b <= SEED_B_RST;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        CFG_SEED_A: seed_a <= cfg_data;
        CFG_SEED_B: seed_b <= cfg_data;
        default:    ;
      endcase
    end
  end

  // ---- pipeline flow: a stage takes a word when empty or draining ----
  assign rdy_c    = !m_tvalid || m_tready;
  assign rdy_b    = !valid_b || rdy_c;
  assign rdy_a    = !valid_a || rdy_b;
  assign s_tready = rdy_a;

  assign load_a = s_tvalid && rdy_a;
  assign load_b = valid_a && rdy_b;
  assign load_c = valid_b && rdy_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a  <= 1'b0;
      valid_b  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy_a) begin
        valid_a <= s_tvalid;
      end
      if (rdy_b) begin
        valid_b <= valid_a;
      end
      if (rdy_c) begin
        m_tvalid <= valid_b;
      end
    end
  end

  // ---- stage A: lanes ----
  assign s_count = s_tdata[DATA_W +: CNT_W];
  assign n_sat   = (s_count > CNT_W'(LANES)) ? CNT_W'(LANES) : s_count;

  always_ff @(posedge clk) begin
    if (load_a) begin
      ctl_a.first <= s_tuser[0];
      ctl_a.n     <= n_sat;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    a32_lane #(
      .LANE_IDX (k)
    ) u_lane (
      .clk      (clk),
      .load     (load_a),
      .byte_in  (s_tdata[k*BYTE_W +: BYTE_W]),
      .count    (n_sat),
      .lane_out (lanes[k])
    );
  end

  // ---- stage B: merge ----
  always_ff @(posedge clk) begin
    if (load_b) begin
      ctl_b <= ctl_a;
    end
  end

  a32_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk   (clk),
    .load  (load_b),
    .lanes (lanes),
    .sums  (sums)
  );

  // ---- stage C: running sums, doubling as the output register ----
  a32_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .load   (load_c),
    .ctl    (ctl_b),
    .sums   (sums),
    .seed_a (seed_a),
    .seed_b (seed_b),
    .acc_a  (acc_a),
    .acc_b  (acc_b)
  );

  assign m_tdata = {acc_b, acc_a, acc_b, acc_a};

endmodule

// ===== hdl/a32_checker.sv =====
// ----------------------------------------------------------------------------
// a32_checker: port-level checks for the Adler-32 lane checksum
// Watches the stream ports for flow, reset and result-range slips.
// ----------------------------------------------------------------------------
module a32_checker import a32_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // a waiting output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a draining output never back-pressures the input
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // an accepted word reaches the output through the lane and merge registers while m_tready stays high
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("word lost in the pipe");

  // sums reduced and checksum packed from them
  a_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] < 16'd65521) && (m_tdata[31:16] < 16'd65521)
                 && (m_tdata[63:32] == m_tdata[31:0]))
    else $error("result word out of range or mispacked");

endmodule

bind adler32_checksum_lanes a32_checker u_a32_checker (.*);
